// File: sv/rthsv_pkg.sv
// Package for the RGB to HSV converter: field widths, sector codes,
// hue offsets, pipeline stage types and the two-bit-per-stage divider step.
// Depends on nothing; used by rgb_to_hsv_convert and rthsv_check.
package rthsv_pkg;

	localparam int unsigned COMP_W = 8;
	localparam int unsigned HUE_W  = 13;
	localparam int unsigned QUO_W  = 10;
	localparam int unsigned NUM_W  = 18;
	localparam int unsigned IN_W   = 24;
	localparam int unsigned OUT_W  = 32;

	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	localparam logic [HUE_W-1:0] HUE_RED_OFS   = 13'd0;
	localparam logic [HUE_W-1:0] HUE_GREEN_OFS = 13'd1920;
	localparam logic [HUE_W-1:0] HUE_BLUE_OFS  = 13'd3840;
	localparam logic [HUE_W-1:0] HUE_FULL      = 13'd5760;

	// Partial state of one restoring division: remainder, numerator bits
	// still to shift in, quotient bits so far, divisor.
	typedef struct packed {
		logic [COMP_W-1:0] rem;
		logic [QUO_W-1:0]  num;
		logic [QUO_W-1:0]  quo;
		logic [COMP_W-1:0] dvsr;
	} div_t;

	typedef struct packed {
		logic              grey;
		logic              neg;
		logic [1:0]        sector;
		logic [COMP_W-1:0] vmax;
	} pix_ctl_t;

	typedef struct packed {
		pix_ctl_t          ctl;
		logic [COMP_W-1:0] delta;
		logic [COMP_W-1:0] adiff;
	} front_t;

	typedef struct packed {
		pix_ctl_t ctl;
		div_t     hdiv;
		div_t     sdiv;
	} div_stage_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [COMP_W-1:0] saturation;
		logic [COMP_W-1:0] brightness;
	} pix_out_t;

	// The quotient is known to stay below 2**QUO_W, so the top numerator
	// bits are already smaller than the divisor.
	function automatic div_t div_init(logic [NUM_W-1:0] n, logic [COMP_W-1:0] dv);
		div_t y;
		y.rem  = n[NUM_W-1:QUO_W];
		y.num  = n[QUO_W-1:0];
		y.quo  = '0;
		y.dvsr = dv;
		return y;
	endfunction

	function automatic div_t div_step(div_t x);
		logic [COMP_W:0] t;
		div_t            y;
		t = {x.rem, x.num[QUO_W-1]};
		y = x;
		if (t >= {1'b0, x.dvsr}) begin
			y.rem = COMP_W'(t - {1'b0, x.dvsr});
			y.quo = {x.quo[QUO_W-2:0], 1'b1};
		end else begin
			y.rem = t[COMP_W-1:0];
			y.quo = {x.quo[QUO_W-2:0], 1'b0};
		end
		y.num = {x.num[QUO_W-2:0], 1'b0};
		return y;
	endfunction

	function automatic div_stage_t stage_step(div_stage_t x);
		div_stage_t y;
		y      = x;
		y.hdiv = div_step(div_step(x.hdiv));
		y.sdiv = div_step(div_step(x.sdiv));
		return y;
	endfunction

endpackage

// File: sv/rgb_to_hsv_convert.sv
// Top level of the RGB to HSV converter: an eight-stage pipeline with
// two radix-2 dividers advancing two quotient bits per stage.
// Depends on rthsv_pkg.
//
// Channel   Dir  Fields (tdata, lowest bit first)
// s_axis    in   red[7:0], green[15:8], blue[23:16]
// m_axis    out  hue[12:0], saturation[20:13], brightness[28:21], zero[31:29]
//
// One pixel is accepted per clock unless a stall has filled the pipeline.
// The depth is set by the ten-bit hue quotient, worked out two bits per
// stage over five stages, plus front, setup and final stages.
// Every stage has its own valid bit and loads when it is empty or its
// successor loads, so bubbles close up and a stall loses or repeats nothing.
// arst_n clears the valid bits only; payload registers are not reset.
module rgb_to_hsv_convert (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [rthsv_pkg::IN_W-1:0]  s_tdata,  // red, green, blue
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [rthsv_pkg::OUT_W-1:0] m_tdata   // hue, saturation, brightness
);
	import rthsv_pkg::*;

	localparam int unsigned NSTG = 8;

	logic [NSTG:1]   vld_q;
	logic [NSTG+1:1] en;

	front_t     front_c, front_s1;
	div_stage_t div_c, div_s2, div_s3, div_s4, div_s5, div_s6, div_s7;
	pix_out_t   out_c, out_s8;

	logic [COMP_W-1:0] red, green, blue, mx, mn;
	logic [COMP_W:0]   diff9;

	// Load enables: a stage takes new data when it is empty or when the
	// stage after it takes its current content.
	always_comb begin
		en[NSTG+1] = m_tready;
		for (int k = NSTG; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	assign s_tready = en[1];
	assign m_tvalid = vld_q[NSTG];
	assign m_tdata  = {3'b000, out_s8.brightness, out_s8.saturation, out_s8.hue};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= s_tvalid;
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// Stage 1: maximum, minimum, sector and signed channel difference.
	// Red wins ties for the maximum, then green.
	always_comb begin
		red   = s_tdata[7:0];
		green = s_tdata[15:8];
		blue  = s_tdata[23:16];
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (mx == red) begin
			front_c.ctl.sector = SEC_RED;
			diff9 = {1'b0, green} - {1'b0, blue};
		end else if (mx == green) begin
			front_c.ctl.sector = SEC_GREEN;
			diff9 = {1'b0, blue} - {1'b0, red};
		end else begin
			front_c.ctl.sector = SEC_BLUE;
			diff9 = {1'b0, red} - {1'b0, green};
		end
		// A black pixel also has max equal to min, so one test covers both.
		front_c.ctl.grey = (mx == mn);
		front_c.ctl.neg  = diff9[COMP_W];
		front_c.ctl.vmax = mx;
		front_c.delta    = mx - mn;
		front_c.adiff    = diff9[COMP_W] ? COMP_W'(9'd0 - diff9) : diff9[COMP_W-1:0];
	end

	// Stage 2: numerators 960*|diff| and 255*delta by shift and subtract.
	always_comb begin
		div_c.ctl  = front_s1.ctl;
		div_c.hdiv = div_init(NUM_W'({front_s1.adiff, 10'b0}) - NUM_W'({front_s1.adiff, 6'b0}),
			front_s1.delta);
		div_c.sdiv = div_init(NUM_W'({front_s1.delta, 8'b0}) - NUM_W'(front_s1.delta),
			front_s1.ctl.vmax);
	end

	// Stage 8: apply the floor for negative differences, add the sector
	// offset, wrap negative hues into range and zero a grey pixel's hue and saturation.
	always_comb begin
		logic [HUE_W-1:0] ofs;
		logic [QUO_W:0]   qa;
		case (div_s7.ctl.sector)
			SEC_GREEN: ofs = HUE_GREEN_OFS;
			SEC_BLUE:  ofs = HUE_BLUE_OFS;
			default:   ofs = HUE_RED_OFS;
		endcase
		qa = {1'b0, div_s7.hdiv.quo}
			+ (QUO_W+1)'(div_s7.ctl.neg && (div_s7.hdiv.rem != '0));
		out_c.brightness = div_s7.ctl.vmax;
		if (div_s7.ctl.grey) begin
			out_c.hue        = '0;
			out_c.saturation = '0;
		end else begin
			out_c.saturation = div_s7.sdiv.quo[COMP_W-1:0];
			if (div_s7.ctl.neg) begin
				if (HUE_W'(qa) > ofs) begin
					out_c.hue = HUE_FULL + ofs - HUE_W'(qa);
				end else begin
					out_c.hue = ofs - HUE_W'(qa);
				end
			end else begin
				out_c.hue = ofs + HUE_W'(div_s7.hdiv.quo);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) front_s1 <= front_c;
		if (en[2]) div_s2   <= div_c;
		if (en[3]) div_s3   <= stage_step(div_s2);
		if (en[4]) div_s4   <= stage_step(div_s3);
		if (en[5]) div_s5   <= stage_step(div_s4);
		if (en[6]) div_s6   <= stage_step(div_s5);
		if (en[7]) div_s7   <= stage_step(div_s6);
		if (en[8]) out_s8   <= out_c;
	end

endmodule

// File: sv/rthsv_check.sv
// Port-level checker for rgb_to_hsv_convert, attached by a bind statement.
// Depends on rthsv_pkg and on the ports of rgb_to_hsv_convert.
module rthsv_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [rthsv_pkg::OUT_W-1:0] m_tdata
);
	import rthsv_pkg::*;

	logic [HUE_W-1:0]  hue;
	logic [COMP_W-1:0] saturation, brightness;

	assign hue        = m_tdata[12:0];
	assign saturation = m_tdata[20:13];
	assign brightness = m_tdata[28:21];

	// A stalled result transfer keeps its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// With the output side draining, the pipeline must take input.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input blocked while output ready");

	a_hue_rng: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> hue < HUE_FULL)
		else $error("hue out of range");

	// Zero saturation only arises from a grey pixel, whose hue is zero.
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && saturation == '0 |-> hue == '0)
		else $error("grey pixel with nonzero hue");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && brightness == '0 |-> saturation == '0)
		else $error("black pixel with nonzero saturation");

endmodule

bind rgb_to_hsv_convert rthsv_check u_rthsv_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: verif/tb.sv
// Self-checking bench for rgb_to_hsv_convert: directed corner pixels, then random pixels,
// with random idling on both stream sides, each result checked against a built-in predictor.
// Depends on rthsv_pkg and rgb_to_hsv_convert.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rthsv_pkg::*;

	localparam int HUE_SECTOR = 960;
	localparam int SAT_SCALE  = 255;
	localparam int IDLE_PCT   = 35;
	localparam int QUIET_MAX  = 2000;
	localparam int DRAIN_CYC  = 16;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata  = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;

	// Expected HSV values, oldest first, one per accepted pixel.
	pix_out_t pending_hsv[$];
	bit       idle_on   = 1'b1;
	int       n_pixels  = 0;
	int       n_checked = 0;
	int       n_errors  = 0;

	rgb_to_hsv_convert i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Exact integer HSV of one pixel. Hue uses a floor division, so a
	// negative sector difference rounds toward minus infinity before the wrap.
	function automatic pix_out_t hsv_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int       vmax, vmin, delta, diff, ofs, num, hue, sat;
		pix_out_t p;
		vmax = r;
		vmin = r;
		if (g > vmax) vmax = g;
		if (b > vmax) vmax = b;
		if (g < vmin) vmin = g;
		if (b < vmin) vmin = b;
		hue = 0;
		sat = 0;
		if (vmax != 0 && vmax != vmin) begin
			delta = vmax - vmin;
			sat = (SAT_SCALE * delta) / vmax;
			// Red wins ties with green or blue, then green wins over blue.
			if (vmax == r) begin
				diff = int'(g) - int'(b);
				ofs  = HUE_RED_OFS;
			end else if (vmax == g) begin
				diff = int'(b) - int'(r);
				ofs  = HUE_GREEN_OFS;
			end else begin
				diff = int'(r) - int'(g);
				ofs  = HUE_BLUE_OFS;
			end
			num = HUE_SECTOR * diff;
			if (num >= 0)
				hue = num / delta;
			else
				hue = -((-num + delta - 1) / delta);
			hue = hue + ofs;
			if (hue < 0)
				hue = hue + HUE_FULL;
		end
		p.hue        = hue[HUE_W-1:0];
		p.saturation = sat[COMP_W-1:0];
		p.brightness = vmax[COMP_W-1:0];
		return p;
	endfunction

	// Receiver side: drops ready in about a third of the cycles while idling is on.
	always @(posedge clk) begin
		if (idle_on)
			m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
		else
			m_tready <= 1'b1;
	end

	// Every pixel transfer into the block queues its expected result.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			pending_hsv.push_back(hsv_of(s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]));
			n_pixels++;
		end
	end

	// Every result transfer is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		pix_out_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_hsv.size() == 0) begin
				$display("%0t: result with nothing expected, tdata=%h", $time, m_tdata);
				n_errors++;
			end else begin
				want = pending_hsv.pop_front();
				n_checked++;
				if (m_tdata[12:0] !== want.hue) begin
					$display("%0t: hue expected %0d actual %0d", $time, want.hue,
						m_tdata[12:0]);
					n_errors++;
				end
				if (m_tdata[20:13] !== want.saturation) begin
					$display("%0t: saturation expected %0d actual %0d", $time,
						want.saturation, m_tdata[20:13]);
					n_errors++;
				end
				if (m_tdata[28:21] !== want.brightness) begin
					$display("%0t: brightness expected %0d actual %0d", $time,
						want.brightness, m_tdata[28:21]);
					n_errors++;
				end
				if (m_tdata[31:29] !== 3'b000) begin
					$display("%0t: pad bits expected 0 actual %b", $time, m_tdata[31:29]);
					n_errors++;
				end
			end
		end
	end

	// Watchdog: too many cycles in a row without any transfer ends the run.
	always @(posedge clk) begin : watchdog
		int quiet;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_MAX) begin
			$display("%0t: no transfer for %0d cycles", $time, QUIET_MAX);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Sends one pixel. Called and returns on a rising edge; tvalid stays high
	// on return so back-to-back pixels need no extra assignment. While idling
	// is on, each cycle before the pixel is idle with the idle percentage.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, g, r};
		do @(posedge clk); while (!s_tready);
	endtask

	// Random pixel drawn from a few shapes: uniform, nearly grey, two
	// channels tied, and channels near the ends of the range.
	task automatic send_random_pixel();
		logic [7:0] c[3];
		int         base, v, k, j;
		case ($urandom_range(0, 3))
			0: begin
				for (k = 0; k < 3; k++) c[k] = 8'($urandom_range(0, 255));
			end
			1: begin
				base = $urandom_range(0, 255);
				for (k = 0; k < 3; k++) begin
					v = base + $urandom_range(0, 6) - 3;
					if (v < 0) v = 0;
					if (v > 255) v = 255;
					c[k] = v[7:0];
				end
			end
			2: begin
				for (k = 0; k < 3; k++) c[k] = 8'($urandom_range(0, 255));
				k = $urandom_range(0, 2);
				j = (k + $urandom_range(1, 2)) % 3;
				c[j] = c[k];
			end
			default: begin
				for (k = 0; k < 3; k++)
					case ($urandom_range(0, 4))
						0: c[k] = 8'd0;
						1: c[k] = 8'd1;
						2: c[k] = 8'd254;
						3: c[k] = 8'd255;
						default: c[k] = 8'($urandom_range(0, 255));
					endcase
			end
		endcase
		send_pixel(c[0], c[1], c[2]);
	endtask

	// Black, grey, primaries, every tie between channels, hue wrap and
	// the extremes of each component.
	task automatic test_corners();
		send_pixel(8'd0,   8'd0,   8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd1,   8'd1,   8'd1);
		send_pixel(8'd255, 8'd0,   8'd0);
		send_pixel(8'd0,   8'd255, 8'd0);
		send_pixel(8'd0,   8'd0,   8'd255);
		send_pixel(8'd255, 8'd0,   8'd1);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0,   8'd255, 8'd255);
		send_pixel(8'd255, 8'd0,   8'd255);
		send_pixel(8'd1,   8'd0,   8'd0);
		send_pixel(8'd0,   8'd1,   8'd0);
		send_pixel(8'd0,   8'd0,   8'd1);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd254, 8'd255, 8'd254);
		send_pixel(8'd254, 8'd254, 8'd255);
		send_pixel(8'd200, 8'd100, 8'd199);
		send_pixel(8'd2,   8'd1,   8'd0);
		send_pixel(8'd0,   8'd1,   8'd2);
		send_pixel(8'd170, 8'd85,  8'd255);
	endtask

	task automatic test_random_idle(input int count);
		idle_on = 1'b1;
		repeat (count) send_random_pixel();
	endtask

	// Full-rate stretch: both sides always ready, one pixel per clock.
	task automatic test_full_rate(input int count);
		idle_on = 1'b0;
		repeat (count) send_random_pixel();
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_random_idle(700);
		test_full_rate(300);
		test_random_idle(730);

		s_tvalid <= 1'b0;
		while (pending_hsv.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("Converted %0d pixels (corner cases, channel ties, near-grey and random);",
			n_pixels);
		$display("%0d results compared, %0d mismatches.", n_checked, n_errors);
		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: filelist.f
sv/rthsv_pkg.sv
sv/rgb_to_hsv_convert.sv
sv/rthsv_check.sv
verif/tb.sv
